// File: sv/spd_pkg.sv
// shared constants, codes and types of the shortest path engine
package spd_pkg;

  localparam int MAX_NODES  = 256;
  localparam int NODE_W     = 8;
  localparam int NCFG_W     = 9;
  localparam int EDGE_CAP   = 16;
  localparam int SLOT_W     = 4;
  localparam int ECNT_W     = 5;
  localparam int EADDR_W    = NODE_W + SLOT_W;
  localparam int WEIGHT_W   = 16;
  localparam int DIST_W     = 24;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [NCFG_W-1:0] NODES_LIM = NCFG_W'(MAX_NODES);
  localparam logic [ECNT_W-1:0] EDGE_FULL = ECNT_W'(EDGE_CAP);

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  localparam logic [1:0] ST_FOUND   = 2'd0;
  localparam logic [1:0] ST_UNREACH = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  typedef struct packed {
    logic [NODE_W-1:0]   dest;
    logic [WEIGHT_W-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic                en;
    logic [NODE_W-1:0]   node;
    logic [SLOT_W-1:0]   slot;
    edge_t               data;
    logic [ECNT_W-1:0]   count;
  } edge_wr_t;

endpackage

// File: sv/spd_in_if.sv
// input channel: edge inserts and path queries
interface spd_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] from_node;
  logic [7:0] to_node;
  logic [15:0] weight;

  modport source (output valid, action, from_node, to_node, weight, input ready);
  modport sink   (input valid, action, from_node, to_node, weight, output ready);
endinterface

// File: sv/spd_out_if.sv
// output channel: distance and status results
interface spd_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] distance;
  logic [1:0]  status;

  modport source (output valid, distance, status, input ready);
  modport sink   (input valid, distance, status, output ready);
endinterface

// File: sv/spd_edge_store.sv
// per-node edge lists and edge counts, counts cleared by valid bits
module spd_edge_store (
  input  logic                          clk,
  input  logic                          rst,
  input  spd_pkg::edge_wr_t             wr,
  input  logic [spd_pkg::NODE_W-1:0]    cnt_rd_node,
  output logic [spd_pkg::ECNT_W-1:0]    cnt_rd_data,
  input  logic [spd_pkg::EADDR_W-1:0]   edge_rd_addr,
  output spd_pkg::edge_t                edge_rd_data
);
  import spd_pkg::*;

  logic [ECNT_W-1:0] cnt_mem [MAX_NODES];
  edge_t             edge_mem [MAX_NODES*EDGE_CAP];
  logic [MAX_NODES-1:0] cnt_vld;
  logic [ECNT_W-1:0] cnt_q;
  logic              vld_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      cnt_mem[wr.node] <= wr.count;
      edge_mem[{wr.node, wr.slot}] <= wr.data;
    end
    cnt_q <= cnt_mem[cnt_rd_node];
    edge_rd_data <= edge_mem[edge_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld <= '0;
      vld_q <= 1'b0;
    end else begin
      vld_q <= cnt_vld[cnt_rd_node];
      if (wr.en) cnt_vld[wr.node] <= 1'b1;
    end
  end

  // a list never written reads as empty
  assign cnt_rd_data = vld_q ? cnt_q : '0;
endmodule

// File: sv/spd_dist_ram.sv
// best distance per node, one write and one registered read port
module spd_dist_ram (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [spd_pkg::NODE_W-1:0]  wr_addr,
  input  logic [spd_pkg::DIST_W-1:0]  wr_data,
  input  logic [spd_pkg::NODE_W-1:0]  rd_addr,
  output logic [spd_pkg::DIST_W-1:0]  rd_data
);
  import spd_pkg::*;

  logic [DIST_W-1:0] mem [MAX_NODES];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

// File: sv/shortest_path_dijkstra_dense_top.sv
// top level: dijkstra engine over per-node edge lists held in memories
//
//   channel   dir  transfer when          payload
//   in_ch     in   valid & ready          action, from_node, to_node, weight
//   out_ch    out  valid & ready          distance, status
//   cfg       in   cfg_we                 cfg_data = node_count
//
// a query is bound by the serial scan over the distance memory (one read per
// cycle), repeated for each node reached, plus the walk over each picked
// node's edge list. no clearing pass after reset.
// one item at a time; a waiting result holds in the output register while
// the next item is taken. rst is synchronous, active high.
module shortest_path_dijkstra_dense_top (
  input  logic       clk,
  input  logic       rst,
  spd_in_if.sink     in_ch,
  spd_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [8:0] cfg_data
);
  import spd_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INS   = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_PICK  = 4'd3;
  localparam logic [3:0] S_CNT   = 4'd4;
  localparam logic [3:0] S_EREQ  = 4'd5;
  localparam logic [3:0] S_ERSP  = 4'd6;
  localparam logic [3:0] S_DRSP  = 4'd7;
  localparam logic [3:0] S_TGT   = 4'd8;
  localparam logic [3:0] S_TWAIT = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  logic [3:0]          state;
  logic [NCFG_W-1:0]   node_count;
  logic [NCFG_W-1:0]   n_eff;
  logic [NODE_W-1:0]   op_from, op_to;
  logic [WEIGHT_W-1:0] op_w;
  logic [MAX_NODES-1:0] known, done;
  logic [NCFG_W-1:0]   scan_idx;
  logic                rd_pend, have;
  logic [NODE_W-1:0]   rd_idx, cur, dnode;
  logic [DIST_W-1:0]   cur_dist, nd, res_dist;
  logic [1:0]          res_status;
  logic [ECNT_W-1:0]   ecnt, eidx;
  logic                out_valid;
  logic [DIST_W-1:0]   out_dist;
  logic [1:0]          out_status;

  edge_wr_t            ewr;
  logic [NODE_W-1:0]   cnt_rd_node;
  logic [ECNT_W-1:0]   cnt_rd_data;
  logic [EADDR_W-1:0]  edge_rd_addr;
  edge_t               edge_rd_data;
  logic                d_we;
  logic [NODE_W-1:0]   d_waddr, d_raddr;
  logic [DIST_W-1:0]   d_wdata, d_rdata;

  logic                in_xfer, in_bad;
  logic [DIST_W:0]     sum;

  assign n_eff   = (node_count > NODES_LIM) ? NODES_LIM : node_count;
  assign in_xfer = in_ch.valid && in_ch.ready;
  assign in_bad  = ({1'b0, in_ch.from_node} >= n_eff) || ({1'b0, in_ch.to_node} >= n_eff);
  assign sum     = {1'b0, cur_dist} + {{(DIST_W+1-WEIGHT_W){1'b0}}, edge_rd_data.weight};

  assign in_ch.ready     = (state == S_IDLE);
  assign out_ch.valid    = out_valid;
  assign out_ch.distance = out_dist;
  assign out_ch.status   = out_status;

  spd_edge_store u_edges (
    .clk          (clk),
    .rst          (rst),
    .wr           (ewr),
    .cnt_rd_node  (cnt_rd_node),
    .cnt_rd_data  (cnt_rd_data),
    .edge_rd_addr (edge_rd_addr),
    .edge_rd_data (edge_rd_data)
  );

  spd_dist_ram u_dist (
    .clk     (clk),
    .wr_en   (d_we),
    .wr_addr (d_waddr),
    .wr_data (d_wdata),
    .rd_addr (d_raddr),
    .rd_data (d_rdata)
  );

  always_comb begin
    ewr.en     = (state == S_INS) && (cnt_rd_data != EDGE_FULL);
    ewr.node   = op_from;
    ewr.slot   = cnt_rd_data[SLOT_W-1:0];
    ewr.data.dest   = op_to;
    ewr.data.weight = op_w;
    ewr.count  = cnt_rd_data + ECNT_W'(1);

    cnt_rd_node  = (state == S_IDLE) ? in_ch.from_node : cur;
    edge_rd_addr = {cur, eidx[SLOT_W-1:0]};

    unique case (state)
      S_SCAN:  d_raddr = scan_idx[NODE_W-1:0];
      S_ERSP:  d_raddr = edge_rd_data.dest;
      default: d_raddr = op_to;
    endcase

    // origin gets distance zero at acceptance, relaxation writes later
    if (state == S_IDLE) begin
      d_we    = in_xfer && !in_bad && (in_ch.action == ACT_QUERY);
      d_waddr = in_ch.from_node;
      d_wdata = '0;
    end else begin
      d_we    = (state == S_DRSP) && (!known[dnode] || nd < d_rdata);
      d_waddr = dnode;
      d_wdata = nd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      node_count <= NODES_LIM;
      out_valid  <= 1'b0;
      known      <= '0;
      done       <= '0;
      rd_pend    <= 1'b0;
      have       <= 1'b0;
    end else begin
      if (cfg_we) node_count <= cfg_data;
      if (out_valid && out_ch.ready && state != S_EMIT) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            op_from <= in_ch.from_node;
            op_to   <= in_ch.to_node;
            op_w    <= in_ch.weight;
            if (in_bad) begin
              res_dist   <= '0;
              res_status <= ST_RANGE;
              state      <= S_EMIT;
            end else if (in_ch.action == ACT_INSERT) begin
              state <= S_INS;
            end else begin
              known    <= {{(MAX_NODES-1){1'b0}}, 1'b1} << in_ch.from_node;
              done     <= '0;
              scan_idx <= '0;
              rd_pend  <= 1'b0;
              have     <= 1'b0;
              state    <= S_SCAN;
            end
          end
        end
        S_INS: begin
          if (cnt_rd_data == EDGE_FULL) begin
            res_dist   <= '0;
            res_status <= ST_FULL;
            state      <= S_EMIT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (scan_idx < n_eff) begin
            scan_idx <= scan_idx + NCFG_W'(1);
            rd_idx   <= scan_idx[NODE_W-1:0];
            rd_pend  <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
          // strict compare keeps the lowest index on ties
          if (rd_pend && known[rd_idx] && !done[rd_idx] && (!have || d_rdata < cur_dist)) begin
            cur      <= rd_idx;
            cur_dist <= d_rdata;
            have     <= 1'b1;
          end
          if (!rd_pend && scan_idx == n_eff) state <= S_PICK;
        end
        S_PICK: begin
          if (have) begin
            done[cur] <= 1'b1;
            state     <= S_CNT;
          end else begin
            state <= S_TGT;
          end
        end
        S_CNT: begin
          ecnt  <= cnt_rd_data;
          eidx  <= '0;
          state <= S_EREQ;
        end
        S_EREQ: begin
          if (eidx == ecnt) begin
            scan_idx <= '0;
            rd_pend  <= 1'b0;
            have     <= 1'b0;
            state    <= S_SCAN;
          end else begin
            state <= S_ERSP;
          end
        end
        S_ERSP: begin
          // stale edges past the node count are skipped
          if ({1'b0, edge_rd_data.dest} >= n_eff) begin
            eidx  <= eidx + ECNT_W'(1);
            state <= S_EREQ;
          end else begin
            dnode <= edge_rd_data.dest;
            nd    <= sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
            state <= S_DRSP;
          end
        end
        S_DRSP: begin
          if (d_we) known[dnode] <= 1'b1;
          eidx  <= eidx + ECNT_W'(1);
          state <= S_EREQ;
        end
        S_TGT: state <= S_TWAIT;
        S_TWAIT: begin
          if (known[op_to]) begin
            res_dist   <= d_rdata;
            res_status <= ST_FOUND;
          end else begin
            res_dist   <= '0;
            res_status <= ST_UNREACH;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || out_ch.ready) begin
            out_valid  <= 1'b1;
            out_dist   <= res_dist;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pick_unsettled: assert property (@(posedge clk) disable iff (rst)
    (state == S_PICK && have) |-> !done[cur] && known[cur])
    else $error("picked node already settled or unknown");

  a_edge_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EREQ) |-> (eidx <= ecnt && ecnt <= EDGE_FULL))
    else $error("edge index past list length");

  a_relax_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRSP) |-> ({1'b0, dnode} < n_eff))
    else $error("relaxing node out of range");

  a_insert_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS && cnt_rd_data != EDGE_FULL) |=> state == S_IDLE && !$past(out_valid && !out_ch.ready) || state == S_IDLE)
    else $error("insert did not return to idle");
endmodule

// File: dv/tb_shortest_path_dijkstra_dense_top.sv
// testbench for the dijkstra shortest path engine: inserts, queries and node count changes
`timescale 1ns / 1ps

module tb_shortest_path_dijkstra_dense_top;
  import spd_pkg::*;

  localparam longint CYCLE_LIMIT = 64'd60_000_000;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [1:0]        status;
  } path_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [8:0] cfg_data = '0;

  spd_in_if  in_ch ();
  spd_out_if out_ch ();

  shortest_path_dijkstra_dense_top dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // graph copy kept in step with the block
  int unsigned n_cfg;
  int unsigned out_deg [MAX_NODES];
  int unsigned adj_to [MAX_NODES][EDGE_CAP];
  int unsigned adj_w [MAX_NODES][EDGE_CAP];
  path_result_t pending_results [$];
  int errors = 0;
  longint cycles = 0;
  int unsigned hold_cycles = 0;
  bit stall_en = 1'b1;

  function automatic int unsigned node_limit();
    return (n_cfg > MAX_NODES) ? MAX_NODES : n_cfg;
  endfunction

  function automatic path_result_t shortest_path(int unsigned src, int unsigned dst);
    int unsigned n;
    int unsigned path_dist [MAX_NODES];
    bit known [MAX_NODES];
    bit settled [MAX_NODES];
    int unsigned cur;
    bit have;
    longint unsigned nd;
    int unsigned d;
    path_result_t r;
    n = node_limit();
    for (int k = 0; k < MAX_NODES; k++) begin
      known[k] = 0;
      settled[k] = 0;
      path_dist[k] = 0;
    end
    path_dist[src] = 0;
    known[src] = 1;
    for (int i = 0; i < n; i++) begin
      have = 0;
      cur = 0;
      for (int j = 0; j < n; j++) begin
        if (!settled[j] && known[j] && (!have || path_dist[j] < path_dist[cur])) begin
          cur = j;
          have = 1;
        end
      end
      if (!have) break;
      settled[cur] = 1;
      for (int e = 0; e < out_deg[cur]; e++) begin
        d = adj_to[cur][e];
        if (d >= n) continue;
        nd = longint'(path_dist[cur]) + adj_w[cur][e];
        if (nd > DIST_MAX) nd = DIST_MAX;
        if (!known[d] || nd < path_dist[d]) begin
          path_dist[d] = nd[31:0];
          known[d] = 1;
        end
      end
    end
    r.distance = known[dst] ? DIST_W'(path_dist[dst]) : '0;
    r.status = known[dst] ? ST_FOUND : ST_UNREACH;
    return r;
  endfunction

  // updates the graph copy and queues the expected result, if any
  function automatic void predict_item(logic act, int unsigned src, int unsigned dst,
                                       int unsigned w);
    path_result_t r;
    if (src >= node_limit() || dst >= node_limit()) begin
      r.distance = '0;
      r.status = ST_RANGE;
      pending_results.push_back(r);
    end else if (act == ACT_INSERT) begin
      if (out_deg[src] >= EDGE_CAP) begin
        r.distance = '0;
        r.status = ST_FULL;
        pending_results.push_back(r);
      end else begin
        adj_to[src][out_deg[src]] = dst;
        adj_w[src][out_deg[src]] = w;
        out_deg[src]++;
      end
    end else begin
      pending_results.push_back(shortest_path(src, dst));
    end
  endfunction

  // sender bursts and gaps
  int burst_left = 0;

  task automatic send_item(logic act, int unsigned src, int unsigned dst, int unsigned w);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
    burst_left--;
    in_ch.valid = 1'b1;
    in_ch.action = act;
    in_ch.from_node = src[7:0];
    in_ch.to_node = dst[7:0];
    in_ch.weight = w[15:0];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_item(act, src, dst, w);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_node_count(int unsigned v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v[8:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    n_cfg = v;
  endtask

  // receiver stall pattern, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_cycles != 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (stall_en) begin
      out_ch.ready <= (cycles % 37 < 20) ? ($urandom_range(0, 3) != 0) : 1'b1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    path_result_t exp_r;
    cycles <= cycles + 1;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result distance=%0d status=%0d", $time,
                 out_ch.distance, out_ch.status);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.distance !== exp_r.distance)
          begin
          $display("%0t: distance expected %0d actual %0d", $time,
                   exp_r.distance, out_ch.distance);
          errors++;
        end
        if (out_ch.status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   exp_r.status, out_ch.status);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_shortest_path_dijkstra_dense_top NOT OK");
      $finish;
    end
  end

  task automatic test_directed();
    set_node_count(8);
    send_item(ACT_QUERY, 0, 0, 16'hFFFF);           // origin is target
    send_item(ACT_QUERY, 0, 7, 0);                  // no edges yet
    send_item(ACT_INSERT, 0, 1, 16'hFFFF);
    send_item(ACT_INSERT, 1, 7, 16'hFFFF);
    send_item(ACT_INSERT, 0, 2, 0);
    send_item(ACT_INSERT, 2, 7, 5);
    send_item(ACT_QUERY, 0, 7, 0);
    send_item(ACT_QUERY, 7, 0, 0);                  // unreachable
    send_item(ACT_INSERT, 8, 0, 1);                 // out of range
    send_item(ACT_QUERY, 0, 255, 0);
    for (int i = 0; i < 17; i++) send_item(ACT_INSERT, 3, i % 8, i);  // fills list
    // lowering the count leaves stale edges
    set_node_count(3);
    send_item(ACT_QUERY, 0, 2, 0);
    send_item(ACT_QUERY, 2, 0, 0);
    set_node_count(0);
    send_item(ACT_QUERY, 0, 0, 0);
    send_item(ACT_INSERT, 0, 0, 1);
    set_node_count(511);                            // saturates
    send_item(ACT_INSERT, 255, 255, 16'hAAAA);
    send_item(ACT_INSERT, 255, 0, 16'h5555);
    send_item(ACT_QUERY, 255, 0, 0);
    send_item(ACT_QUERY, 255, 7, 0);
  endtask

  task automatic test_random(int unsigned cnt, int unsigned n);
    int unsigned src;
    int unsigned dst;
    set_node_count(n);
    for (int i = 0; i < cnt; i++) begin
      // mostly in range, some beyond the count
      src = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, n - 1);
      dst = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, n - 1);
      send_item(($urandom_range(0, 2) == 0) ? ACT_QUERY : ACT_INSERT, src, dst,
                $urandom_range(0, 65535));
    end
  endtask

  task automatic test_backpressure();
    set_node_count(16);
    hold_cycles = 3000;
    for (int i = 0; i < 12; i++) send_item(ACT_QUERY, i, 15 - i, 0);
    drain();
    stall_en = 1'b0;
    test_random(10, 16);
    stall_en = 1'b1;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = ACT_INSERT;
    in_ch.from_node = '0;
    in_ch.to_node = '0;
    in_ch.weight = '0;
    out_ch.ready = 1'b0;
    n_cfg = 256;
    for (int k = 0; k < MAX_NODES; k++) out_deg[k] = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(25, 12);
    test_random(20, 40);
    test_backpressure();
    test_random(10, 256);
    drain();
    if (errors == 0)
      $display("tb_shortest_path_dijkstra_dense_top OK");
    else
      $display("tb_shortest_path_dijkstra_dense_top NOT OK");
    $finish;
  end

endmodule
